// ===== rtl/core/mcavg_pkg.sv =====
// Shared types, constants and codes of the multichannel moving-average block.
package mcavg_pkg;

  // Field layout of the converter data word.
  localparam int IN_W       = 32;
  localparam int CHAN_LSB   = 26;
  localparam int CHAN_W     = 4;
  localparam int SAMPLE_LSB = 4;
  localparam int SAMPLE_W   = 12;

  // Result fields and arithmetic widths.
  localparam int SLOT_IDX_W = 2;
  localparam int AVG_W      = 12;
  localparam int SUM_W      = 16;
  localparam int DCNT_W     = $clog2(SUM_W + 1);

  // Configuration registers.
  localparam int CFG_SLOTS = 4;
  localparam int MAP_W     = CFG_SLOTS * CHAN_W;
  localparam int MASK_W    = CFG_SLOTS;
  localparam int WLEN_W    = 5;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SLOT_MAP   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_MASK  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 2'd2;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd16;

  // Defaults of the top-level parameters.
  localparam int NUM_SLOTS_DEF  = 4;
  localparam int WINDOW_MAX_DEF = 16;

  typedef struct packed {
    logic [IN_W-1:0] adc_word;
  } in_payload_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [CHAN_W-1:0]     channel_number;
    logic                  hit;
    logic [AVG_W-1:0]      average;
    logic                  last;
  } out_payload_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESYNC,
    ST_SCAN,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT,
    ST_MISS
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic rs_start;
    logic rs_step;
    logic load;
    logic slot_next;
    logic upd;
    logic div_step;
    logic out_load;
    logic out_miss;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic resync_done;
    logic any_hit;
    logic slot_hit;
    logic slot_last;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/mcavg_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
interface mcavg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mcavg_cfg_regs.sv =====
// APB-style configuration registers and effective window length.
module mcavg_cfg_regs #(
  parameter int WINDOW_MAX = mcavg_pkg::WINDOW_MAX_DEF,
  localparam int LW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mcavg_pkg::ADDR_W-1:0]     paddr,
  input  logic [mcavg_pkg::DATA_W-1:0]     pwdata,
  output logic [mcavg_pkg::DATA_W-1:0]     prdata,
  output logic                             pready,
  output logic [mcavg_pkg::MAP_W-1:0]      slot_map,
  output logic [mcavg_pkg::MASK_W-1:0]     slot_mask,
  output logic [LW-1:0]                    len_eff,
  output logic                             wlen_wr
);

  logic [mcavg_pkg::MAP_W-1:0]  map_r,  map_nxt;
  logic [mcavg_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic [mcavg_pkg::WLEN_W-1:0] wlen_r, wlen_nxt;
  logic [mcavg_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mcavg_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign wlen_wr = wr_en && (reg_idx == mcavg_pkg::REG_WINDOW_LEN);

  always_comb begin
    map_nxt  = map_r;
    mask_nxt = mask_r;
    wlen_nxt = wlen_r;
    if (wr_en) begin
      case (reg_idx)
        mcavg_pkg::REG_SLOT_MAP:   map_nxt  = pwdata[mcavg_pkg::MAP_W-1:0];
        mcavg_pkg::REG_SLOT_MASK:  mask_nxt = pwdata[mcavg_pkg::MASK_W-1:0];
        mcavg_pkg::REG_WINDOW_LEN: wlen_nxt = pwdata[mcavg_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r  <= '0;
      mask_r <= '0;
      wlen_r <= mcavg_pkg::WLEN_RESET;
    end else begin
      map_r  <= map_nxt;
      mask_r <= mask_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      mcavg_pkg::REG_SLOT_MAP:   prdata = mcavg_pkg::DATA_W'(map_r);
      mcavg_pkg::REG_SLOT_MASK:  prdata = mcavg_pkg::DATA_W'(mask_r);
      mcavg_pkg::REG_WINDOW_LEN: prdata = mcavg_pkg::DATA_W'(wlen_r);
      default:                   prdata = '0;
    endcase
  end

  // Zero counts as one, anything above WINDOW_MAX saturates to WINDOW_MAX.
  always_comb begin
    if (wlen_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(wlen_r) > WINDOW_MAX) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = LW'(wlen_r);
    end
  end

  assign slot_map  = map_r;
  assign slot_mask = mask_r;

endmodule

// ===== rtl/core/mcavg_ctrl.sv =====
// Controller state machine: sequences clearing, resync, slot updates and results.
module mcavg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               wlen_wr,
  input  mcavg_pkg::dp_sts_t sts,
  output mcavg_pkg::dp_cmd_t cmd
);

  mcavg_pkg::ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcavg_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_nxt = mcavg_pkg::ST_IDLE;
      end
      mcavg_pkg::ST_IDLE: begin
        if (wlen_wr) begin
          state_nxt = mcavg_pkg::ST_RESYNC;
        end else if (in_valid) begin
          state_nxt = mcavg_pkg::ST_SCAN;
        end
      end
      mcavg_pkg::ST_RESYNC: begin
        if (!wlen_wr && sts.resync_done) state_nxt = mcavg_pkg::ST_IDLE;
      end
      mcavg_pkg::ST_SCAN: begin
        if (!sts.any_hit) begin
          state_nxt = mcavg_pkg::ST_MISS;
        end else if (sts.slot_hit) begin
          state_nxt = mcavg_pkg::ST_UPDATE;
        end
      end
      mcavg_pkg::ST_UPDATE: state_nxt = mcavg_pkg::ST_DIVIDE;
      mcavg_pkg::ST_DIVIDE: begin
        if (sts.div_done) state_nxt = mcavg_pkg::ST_EMIT;
      end
      mcavg_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.slot_last ? mcavg_pkg::ST_IDLE : mcavg_pkg::ST_SCAN;
        end
      end
      mcavg_pkg::ST_MISS: begin
        if (sts.out_free) state_nxt = mcavg_pkg::ST_IDLE;
      end
      default: state_nxt = mcavg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mcavg_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      mcavg_pkg::ST_IDLE: begin
        in_ready     = !wlen_wr;
        cmd.rs_start = wlen_wr;
        cmd.load     = in_valid && !wlen_wr;
      end
      mcavg_pkg::ST_RESYNC: begin
        cmd.rs_start = wlen_wr;
        cmd.rs_step  = !wlen_wr;
      end
      mcavg_pkg::ST_SCAN: begin
        cmd.slot_next = sts.any_hit && !sts.slot_hit;
      end
      mcavg_pkg::ST_UPDATE: cmd.upd = 1'b1;
      mcavg_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
      mcavg_pkg::ST_EMIT: begin
        cmd.out_load  = sts.out_free;
        cmd.slot_next = sts.out_free && !sts.slot_last;
      end
      mcavg_pkg::ST_MISS: begin
        cmd.out_load = sts.out_free;
        cmd.out_miss = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcavg_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/mcavg_datapath.sv =====
// Datapath: sample rings, running sums, ring positions, serial divider, result register.
module mcavg_datapath #(
  parameter int NUM_SLOTS  = mcavg_pkg::NUM_SLOTS_DEF,
  parameter int WINDOW_MAX = mcavg_pkg::WINDOW_MAX_DEF,
  localparam int LW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcavg_pkg::dp_cmd_t             cmd,
  output mcavg_pkg::dp_sts_t             sts,
  input  logic [mcavg_pkg::IN_W-1:0]     adc_word,
  input  logic [mcavg_pkg::MAP_W-1:0]    slot_map,
  input  logic [mcavg_pkg::MASK_W-1:0]   slot_mask,
  input  logic [LW-1:0]                  len_eff,
  input  logic                           out_ready,
  output logic                           out_valid,
  output mcavg_pkg::out_payload_t        out_payload
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int AW    = SW + PW;
  localparam int DEPTH = NUM_SLOTS * (2 ** PW);
  localparam int CLRW  = $clog2(DEPTH + 1);
  localparam int SUMW  = mcavg_pkg::SUM_W;
  localparam int SMPW  = mcavg_pkg::SAMPLE_W;
  localparam int CHW   = mcavg_pkg::CHAN_W;

  // Sample rings, one row of 2**PW entries per slot.
  logic [SMPW-1:0] mem [DEPTH];
  logic [SMPW-1:0] rdata_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [SMPW-1:0] mem_wdata;

  logic [CHW-1:0]  chan_r, chan_nxt;
  logic [SMPW-1:0] sample_r, sample_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;

  logic [PW-1:0]   pos_r [NUM_SLOTS];
  logic [PW-1:0]   pos_nxt [NUM_SLOTS];
  logic [SUMW-1:0] sum_r [NUM_SLOTS];
  logic [SUMW-1:0] sum_nxt [NUM_SLOTS];

  logic [CLRW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic            clr_done;

  logic [SW-1:0]   rs_slot_r, rs_slot_nxt;
  logic [PW-1:0]   rs_ent_r, rs_ent_nxt;
  logic            rs_all_r, rs_all_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [SW-1:0]   rd_tag_r, rd_tag_nxt;
  logic            rd_first_r, rd_first_nxt;
  logic            rs_last_ent, rs_last_slot;

  logic [LW-1:0]   rem_r, rem_nxt;
  logic [SUMW-1:0] quo_r, quo_nxt;
  logic [mcavg_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic            div_done;
  logic [LW:0]     trial;
  logic            trial_ge;

  logic                    out_valid_r, out_valid_nxt;
  mcavg_pkg::out_payload_t out_pay_r, out_pay_nxt;
  logic                    out_free;

  logic [NUM_SLOTS-1:0] hit_vec, hit_above;
  logic [PW-1:0]   pos_cur, pos_eff, pos_wrap;
  logic [LW:0]     pos_inc;
  logic [SW-1:0]   sum_idx;
  logic [SUMW-1:0] sum_sel, sum_new, sum_acc;

  // Slot match against the latched channel; slots past the register fields never match.
  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_hit
    if (s < mcavg_pkg::CFG_SLOTS) begin : g_cfg
      assign hit_vec[s] = slot_mask[s] && (slot_map[s*CHW +: CHW] == chan_r);
    end else begin : g_none
      assign hit_vec[s] = 1'b0;
    end
  end

  assign hit_above = hit_vec >> slot_r;

  // Ring position of the current slot, wrapped to the window.
  assign pos_cur  = pos_r[slot_r];
  assign pos_eff  = (LW'(pos_cur) >= len_eff) ? '0 : pos_cur;
  assign pos_inc  = (LW + 1)'(pos_eff) + 1'b1;
  assign pos_wrap = (pos_inc >= (LW + 1)'(len_eff)) ? '0 : PW'(pos_inc);

  assign sum_idx = rd_vld_r ? rd_tag_r : slot_r;
  assign sum_sel = sum_r[sum_idx];
  assign sum_new = sum_sel - SUMW'(rdata_r) + SUMW'(sample_r);
  assign sum_acc = (rd_first_r ? '0 : sum_sel) + SUMW'(rdata_r);

  assign clr_done     = (clr_cnt_r == CLRW'(DEPTH));
  assign rs_last_ent  = (LW'(rs_ent_r) == (len_eff - 1'b1));
  assign rs_last_slot = (rs_slot_r == SW'(NUM_SLOTS - 1));
  assign div_done     = (dcnt_r == mcavg_pkg::DCNT_W'(SUMW));
  assign out_free     = !out_valid_r || out_ready;

  assign trial    = {rem_r, quo_r[SUMW-1]};
  assign trial_ge = (trial >= {1'b0, len_eff});

  // Memory ports.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {slot_r, pos_eff};
    mem_wdata = sample_r;
    if (cmd.clr_step && !clr_done) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r[AW-1:0];
      mem_wdata = '0;
    end else if (cmd.upd) begin
      mem_we = 1'b1;
    end
    mem_raddr = cmd.rs_step ? {rs_slot_r, rs_ent_r} : {slot_r, pos_eff};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // Next-state logic.
  always_comb begin
    chan_nxt     = chan_r;
    sample_nxt   = sample_r;
    slot_nxt     = slot_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    clr_cnt_nxt  = clr_cnt_r;
    rs_slot_nxt  = rs_slot_r;
    rs_ent_nxt   = rs_ent_r;
    rs_all_nxt   = rs_all_r;
    rd_vld_nxt   = 1'b0;
    rd_tag_nxt   = rs_slot_r;
    rd_first_nxt = (rs_ent_r == '0);
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    dcnt_nxt     = dcnt_r;

    if (cmd.clr_step && !clr_done) clr_cnt_nxt = clr_cnt_r + 1'b1;

    if (cmd.load) begin
      chan_nxt   = adc_word[mcavg_pkg::CHAN_LSB +: CHW];
      sample_nxt = adc_word[mcavg_pkg::SAMPLE_LSB +: SMPW];
      slot_nxt   = '0;
    end else if (cmd.slot_next) begin
      slot_nxt = slot_r + 1'b1;
    end

    // Resync sweep: issue one ring read per cycle, accumulate the registered read data in the next cycle.
    if (cmd.rs_start) begin
      rs_slot_nxt = '0;
      rs_ent_nxt  = '0;
      rs_all_nxt  = 1'b0;
    end else if (cmd.rs_step) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (LW'(pos_r[s]) >= len_eff) pos_nxt[s] = '0;
      end
      if (rd_vld_r) sum_nxt[rd_tag_r] = sum_acc;
      if (!rs_all_r) begin
        rd_vld_nxt = 1'b1;
        if (rs_last_ent) begin
          rs_ent_nxt = '0;
          if (rs_last_slot) begin
            rs_all_nxt = 1'b1;
          end else begin
            rs_slot_nxt = rs_slot_r + 1'b1;
          end
        end else begin
          rs_ent_nxt = rs_ent_r + 1'b1;
        end
      end
    end

    // Slot update: replace the oldest sample, then start the divider.
    if (cmd.upd) begin
      sum_nxt[slot_r] = sum_new;
      pos_nxt[slot_r] = pos_wrap;
      rem_nxt         = '0;
      quo_nxt         = sum_new;
      dcnt_nxt        = '0;
    end else if (cmd.div_step && !div_done) begin
      rem_nxt  = trial_ge ? LW'(trial - {1'b0, len_eff}) : LW'(trial);
      quo_nxt  = {quo_r[SUMW-2:0], trial_ge};
      dcnt_nxt = dcnt_r + 1'b1;
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pay_nxt   = out_pay_r;
    if (cmd.out_load) begin
      out_valid_nxt              = 1'b1;
      out_pay_nxt.channel_number = chan_r;
      if (cmd.out_miss) begin
        out_pay_nxt.slot_index = '0;
        out_pay_nxt.hit        = 1'b0;
        out_pay_nxt.average    = '0;
        out_pay_nxt.last       = 1'b1;
      end else begin
        out_pay_nxt.slot_index = mcavg_pkg::SLOT_IDX_W'(slot_r);
        out_pay_nxt.hit        = 1'b1;
        out_pay_nxt.average    = quo_r[mcavg_pkg::AVG_W-1:0];
        out_pay_nxt.last       = ((hit_above >> 1) == '0);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '{default: '0};
      sum_r       <= '{default: '0};
      clr_cnt_r   <= '0;
      rs_slot_r   <= '0;
      rs_ent_r    <= '0;
      rs_all_r    <= 1'b1;
      rd_vld_r    <= 1'b0;
      slot_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rs_slot_r   <= rs_slot_nxt;
      rs_ent_r    <= rs_ent_nxt;
      rs_all_r    <= rs_all_nxt;
      rd_vld_r    <= rd_vld_nxt;
      slot_r      <= slot_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r     <= chan_nxt;
    sample_r   <= sample_nxt;
    rd_tag_r   <= rd_tag_nxt;
    rd_first_r <= rd_first_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_pay_r  <= out_pay_nxt;
  end

  always_comb begin
    sts.clear_done  = clr_done;
    sts.resync_done = rs_all_r && !rd_vld_r;
    sts.any_hit     = |hit_vec;
    sts.slot_hit    = hit_vec[slot_r];
    sts.slot_last   = ((hit_above >> 1) == '0);
    sts.div_done    = div_done;
    sts.out_free    = out_free;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_pay_r;

endmodule

// ===== rtl/core/multichannel_adc_moving_average.sv =====
// Top level of the multichannel converter moving-average filter.
//
// Usage: in_if carries one raw converter word per transaction (channel in
// bits 29..26, sample in bits 15..4). Every enabled slot mapped to that
// channel stores the sample in its own ring and reports the truncated mean
// of its window on out_if, in ascending slot order, with last set on the
// final result of the word. A word that matches no slot yields one result
// with hit clear. Configuration goes through the APB port (slot map at 0x0,
// enable mask at 0x4, window length at 0x8); write it only while idle.
//
// Timing: the word is taken in the idle state, then the slots are checked in
// turn; a matching slot goes through a ring read, the update, a 16-step
// bit-serial divider and the loading of the result register. A word with no
// match goes to a single miss result. A window length write triggers a resync
// pass that rebuilds every sum; no word is taken then.
// Reset: a clearing pass zeroes the sample rings, one entry per cycle,
// all NUM_SLOTS * 2**ceil(log2(WINDOW_MAX)) entries (64 by default), before the
// first word is taken. A stalled receiver holds the result register; the
// block keeps working until it needs to load the next result.
module multichannel_adc_moving_average #(
  parameter int NUM_SLOTS  = mcavg_pkg::NUM_SLOTS_DEF,
  parameter int WINDOW_MAX = mcavg_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mcavg_stream_if.sink                 in_if,
  mcavg_stream_if.source               out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcavg_pkg::ADDR_W-1:0] paddr,
  input  logic [mcavg_pkg::DATA_W-1:0] pwdata,
  output logic [mcavg_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int LW = $clog2(WINDOW_MAX + 1);

  mcavg_pkg::dp_cmd_t           cmd;
  mcavg_pkg::dp_sts_t           sts;
  logic [mcavg_pkg::MAP_W-1:0]  slot_map;
  logic [mcavg_pkg::MASK_W-1:0] slot_mask;
  logic [LW-1:0]                len_eff;
  logic                         wlen_wr;
  mcavg_pkg::in_payload_t       in_pay;
  mcavg_pkg::out_payload_t      out_pay;
  logic                         out_valid;

  assign in_pay = in_if.payload;

  // Register file; a window length write also kicks off the resync.
  mcavg_cfg_regs #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .slot_map  (slot_map),
    .slot_mask (slot_mask),
    .len_eff   (len_eff),
    .wlen_wr   (wlen_wr)
  );

  // Sequencer: clear, resync, accept, scan slots, update, divide, emit or miss.
  mcavg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .wlen_wr  (wlen_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, arithmetic and the result register.
  mcavg_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .adc_word    (in_pay.adc_word),
    .slot_map    (slot_map),
    .slot_mask   (slot_mask),
    .len_eff     (len_eff),
    .out_ready   (out_if.ready),
    .out_valid   (out_valid),
    .out_payload (out_pay)
  );

  assign out_if.valid   = out_valid;
  assign out_if.payload = out_pay;

endmodule

// ===== verif/multichannel_adc_moving_average_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: directed table and random converter words against a predictor.
module multichannel_adc_moving_average_test;
  import mcavg_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 11;
  localparam int NUM_SLOTS    = NUM_SLOTS_DEF;
  localparam int WINDOW_MAX   = WINDOW_MAX_DEF;

  // Reset starts a ring-clearing pass and a window write starts a resync
  // pass. Both get some margin.
  localparam int CLEAR_WAIT  = 80;
  localparam int RESYNC_WAIT = 80;
  localparam int IDLE_WAIT   = 8;
  localparam int END_WAIT    = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 26;
  localparam int TIMEOUT_NS  = 2_000_000;

  // Address past the end of the register list: writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;
  typedef enum logic [1:0] {RX_STEADY, RX_PATTERN, RX_RANDOM} rx_mode_t;

  // One directed step: a register write, or a converter word with an
  // optional hand-written result (reg_idx is ignored on word rows).
  typedef struct packed {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [IN_W-1:0]       data;
    logic                  typed;
    out_payload_t          result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 28;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mcavg_stream_if #(.payload_t(in_payload_t))  in_if ();
  mcavg_stream_if #(.payload_t(out_payload_t)) out_if ();

  multichannel_adc_moving_average dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor copy of the block's configuration and per-slot rings.
  logic [MAP_W-1:0]    slot_map   = '0;
  logic [MASK_W-1:0]   slot_mask  = '0;
  logic [WLEN_W-1:0]   window_reg = WLEN_RESET;
  logic [SAMPLE_W-1:0] ring     [NUM_SLOTS][WINDOW_MAX] = '{default: '0};
  logic [3:0]          ring_pos [NUM_SLOTS] = '{default: '0};
  logic [SUM_W-1:0]    ring_sum [NUM_SLOTS] = '{default: '0};

  // Averages still owed by the block, oldest first.
  out_payload_t expected_averages[$];
  int mismatch_count = 0;

  // Receiver hold-off request, raised by the stimulus and served by the receiver.
  logic hold_req = 1'b0;

  // Directed table: registers at reset, all slots on one channel, window
  // length zero and above the maximum, unused address, shrink and grow of
  // the window, two slots sharing channel 15, and misses with hit clear.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0000_0000, 1'b1, '{2'd0, 4'd0,  1'b0, 12'd0,    1'b1}},
    '{ROW_WORD,  REG_SLOT_MAP,   32'hFFFF_FFFF, 1'b1, '{2'd0, 4'd15, 1'b0, 12'd0,    1'b1}},
    '{ROW_WORD,  REG_SLOT_MAP,   32'hC3FF_000F, 1'b1, '{2'd0, 4'd0,  1'b0, 12'd0,    1'b1}},
    '{ROW_WRITE, REG_SLOT_MAP,   32'hFFFF_0000, 1'b0, '0},
    '{ROW_WRITE, REG_SLOT_MASK,  32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0000_FFF0, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0000_8000, 1'b0, '0},
    '{ROW_WRITE, REG_WINDOW_LEN, 32'h0000_0000, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0000_FFF0, 1'b0, '0},
    '{ROW_WRITE, REG_SLOT_MAP,   32'h0000_3210, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0000_FFF0, 1'b1, '{2'd0, 4'd0,  1'b1, 12'd4095, 1'b1}},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0C00_0000, 1'b1, '{2'd3, 4'd3,  1'b1, 12'd0,    1'b1}},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h1400_1230, 1'b1, '{2'd0, 4'd5,  1'b0, 12'd0,    1'b1}},
    '{ROW_WRITE, REG_WINDOW_LEN, 32'h0000_001F, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0400_ABC0, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0800_FFF0, 1'b0, '0},
    '{ROW_WRITE, REG_UNUSED,     32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_WRITE, REG_WINDOW_LEN, 32'h0000_0010, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0400_5550, 1'b0, '0},
    '{ROW_WRITE, REG_WINDOW_LEN, 32'h0000_0003, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0800_0010, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0800_7FF0, 1'b0, '0},
    '{ROW_WRITE, REG_SLOT_MAP,   32'h0000_0F0F, 1'b0, '0},
    '{ROW_WRITE, REG_SLOT_MASK,  32'h0000_0005, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h3C00_FFF0, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h0000_1110, 1'b1, '{2'd0, 4'd0,  1'b0, 12'd0,    1'b1}},
    '{ROW_WRITE, REG_WINDOW_LEN, 32'h0000_0011, 1'b0, '0},
    '{ROW_WORD,  REG_SLOT_MAP,   32'h3C00_4440, 1'b0, '0}
  };

  // Window length as the block uses it: zero acts as one, large values clip.
  function automatic int effective_window();
    if (window_reg == '0) return 1;
    if (window_reg > WINDOW_MAX) return WINDOW_MAX;
    return int'(window_reg);
  endfunction

  // Mirror a register write into the predictor. A window change pulls
  // stale write positions back to zero and rebuilds every sum.
  function automatic void apply_register_write(input logic [REG_IDX_W-1:0] idx,
                                               input logic [DATA_W-1:0] value);
    int len;
    case (idx)
      REG_SLOT_MAP:  slot_map  = value[MAP_W-1:0];
      REG_SLOT_MASK: slot_mask = value[MASK_W-1:0];
      REG_WINDOW_LEN: begin
        window_reg = value[WLEN_W-1:0];
        len = effective_window();
        for (int s = 0; s < NUM_SLOTS; s++) begin
          ring_sum[s] = '0;
          for (int e = 0; e < len; e++) ring_sum[s] += SUM_W'(ring[s][e]);
          if (ring_pos[s] >= len) ring_pos[s] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Store the word's sample in every matching slot and work out the
  // averages it produces, in slot order; a miss yields one hit-clear result.
  function automatic int predict_averages(input logic [IN_W-1:0] word,
                                          output out_payload_t res [NUM_SLOTS]);
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] sample;
    int len;
    int pos;
    int count;
    chan   = word[CHAN_LSB +: CHAN_W];
    sample = word[SAMPLE_LSB +: SAMPLE_W];
    len    = effective_window();
    count  = 0;
    foreach (res[k]) res[k] = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!slot_mask[s] || slot_map[CHAN_W*s +: CHAN_W] != chan) continue;
      pos = int'(ring_pos[s]);
      if (pos >= len) pos = 0;
      ring_sum[s] = ring_sum[s] - SUM_W'(ring[s][pos]) + SUM_W'(sample);
      ring[s][pos] = sample;
      pos++;
      if (pos >= len) pos = 0;
      ring_pos[s] = 4'(pos);
      res[count] = '{slot_index: SLOT_IDX_W'(s), channel_number: chan, hit: 1'b1,
                     average: AVG_W'(ring_sum[s] / SUM_W'(len)), last: 1'b0};
      count++;
    end
    if (count == 0) begin
      res[0] = '{slot_index: '0, channel_number: chan, hit: 1'b0, average: '0, last: 1'b1};
      count = 1;
    end else begin
      res[count-1].last = 1'b1;
    end
    return count;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Compare one result transaction with the oldest owed average.
  task automatic check_result(input out_payload_t got);
    out_payload_t want;
    if (expected_averages.size() == 0) begin
      report_mismatch($sformatf("result with nothing owed: %p", got));
    end else begin
      want = expected_averages.pop_front();
      if (got.slot_index !== want.slot_index)
        report_mismatch($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
      if (got.channel_number !== want.channel_number)
        report_mismatch($sformatf("channel_number %0d, want %0d",
                                  got.channel_number, want.channel_number));
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %0b, want %0b (slot %0d)", got.hit, want.hit,
                                  want.slot_index));
      if (got.average !== want.average)
        report_mismatch($sformatf("average %0d, want %0d (slot %0d)", got.average,
                                  want.average, want.slot_index));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b (slot %0d)", got.last, want.last,
                                  want.slot_index));
    end
  endtask

  // One APB transfer, entered and left at a falling edge, that drops psel and
  // lets the bus go idle before returning, so back-to-back calls never retoggle psel in one step.
  task automatic apb_transfer(input logic is_write, input logic [REG_IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write a register, let a resync pass finish after a window write, then read the register back unless it is unused.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    logic [DATA_W-1:0] stored;
    apb_transfer(1'b1, idx, value, readback);
    apply_register_write(idx, value);
    if (idx == REG_WINDOW_LEN) repeat (RESYNC_WAIT) @(negedge clk);
    if (idx != REG_UNUSED) begin
      case (idx)
        REG_SLOT_MAP:  stored = DATA_W'(slot_map);
        REG_SLOT_MASK: stored = DATA_W'(slot_mask);
        default:       stored = DATA_W'(window_reg);
      endcase
      apb_transfer(1'b0, idx, '0, readback);
      if (readback !== stored)
        report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, readback, stored));
    end
  endtask

  // Drop valid, wait for every owed average, then let the block settle.
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (expected_averages.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  // Offer one word until it is taken, then record what it should produce.
  // Valid stays high on return so a following word goes out back to back.
  task automatic send_word(input logic [IN_W-1:0] word, input logic typed,
                           input out_payload_t typed_result);
    out_payload_t predicted [NUM_SLOTS];
    int count;
    in_if.valid   <= 1'b1;
    in_if.payload <= word;
    do @(posedge clk); while (!in_if.ready);
    count = predict_averages(word, predicted);
    if (typed) begin
      expected_averages.push_back(typed_result);
    end else begin
      for (int k = 0; k < count; k++) expected_averages.push_back(predicted[k]);
    end
    @(negedge clk);
  endtask

  // Check every result transaction at the rising edge it is taken.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result(out_if.payload);
  end

  // Receiver: switch at random between always-ready, a rotating pattern and ready
  // three times in four at random; serve long hold-off requests first.
  initial begin
    rx_mode_t    rx_mode;
    logic [31:0] rx_pattern;
    int          rx_left;
    int          hold_left;
    rx_mode    = RX_STEADY;
    rx_pattern = '0;
    rx_left    = 0;
    hold_left  = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        if (rx_left == 0) begin
          rx_mode    = rx_mode_t'($urandom_range(0, 2));
          rx_pattern = $urandom;
          rx_left    = 48;
        end
        rx_left--;
        case (rx_mode)
          RX_STEADY:  out_if.ready <= 1'b1;
          RX_PATTERN: out_if.ready <= rx_pattern[rx_left % 32];
          default:    out_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Stimulus: reset, directed table, then randomized configuration phases.
  initial begin
    logic [IN_W-1:0]   word;
    logic [DATA_W-1:0] reg_val;
    int                burst_left;
    int                gap;
    int                slot;
    burst_left = 0;
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    // Hold off while the block clears its rings after reset.
    repeat (CLEAR_WAIT) @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle_idle();
        write_register(directed_rows[r].reg_idx, directed_rows[r].data);
      end else begin
        send_word(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].result);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle_idle();

      // Phase 1 puts every slot on one channel; the rest map at random.
      reg_val = $urandom;
      if (phase == 1) reg_val[MAP_W-1:0] = {CFG_SLOTS{4'($urandom_range(0, 15))}};
      write_register(REG_SLOT_MAP, reg_val);

      reg_val = $urandom;
      if (phase < 2) reg_val[MASK_W-1:0] = '1;
      else if (reg_val[MASK_W-1:0] == '0) reg_val[0] = 1'b1;
      write_register(REG_SLOT_MASK, reg_val);

      // Cover the shortest, full, clipped and zero window, then random ones.
      reg_val = $urandom;
      case (phase)
        0:       reg_val[WLEN_W-1:0] = 5'd1;
        1:       reg_val[WLEN_W-1:0] = 5'd16;
        2:       reg_val[WLEN_W-1:0] = 5'd31;
        3:       reg_val[WLEN_W-1:0] = 5'd0;
        default: reg_val[WLEN_W-1:0] = WLEN_W'($urandom_range(2, 15));
      endcase
      write_register(REG_WINDOW_LEN, reg_val);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Stall the receiver for a long stretch while words keep coming,
        // so the result register fills and the input backs up.
        if (phase == 3 && i == 6) hold_req = 1'b1;
        // Pause the sender until every owed average is out.
        if (phase == 4 && i == PHASE_ITEMS / 2) settle_idle();

        // Bursts with random gaps; phase 2 runs with no sender gaps.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          gap = (phase == 2) ? 0 : $urandom_range(0, 6);
          if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left--;

        // Mostly words aimed at an enabled slot, the rest raw noise.
        word = $urandom;
        if ($urandom_range(0, 3) != 0) begin
          do slot = $urandom_range(0, NUM_SLOTS - 1); while (!slot_mask[slot]);
          word[CHAN_LSB +: CHAN_W] = slot_map[CHAN_W*slot +: CHAN_W];
        end
        if ($urandom_range(0, 7) == 0) word[SAMPLE_LSB +: SAMPLE_W] = {SAMPLE_W{word[0]}};
        send_word(word, 1'b0, '0);
      end
    end

    settle_idle();
    repeat (END_WAIT) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mcavg_pkg.sv
rtl/core/mcavg_stream_if.sv
rtl/core/mcavg_cfg_regs.sv
rtl/core/mcavg_ctrl.sv
rtl/core/mcavg_datapath.sv
rtl/core/multichannel_adc_moving_average.sv
verif/multichannel_adc_moving_average_test.sv
